### rtl/wmm_pkg.sv
// Package for the window min/max/mean tracker: sizes, field widths and the
// divider stage record shared by the control block, the divider cells and the top level.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package wmm_pkg;

   localparam int VALUE_W      = 32;
   localparam int CHAN_W       = 2;
   localparam int CFG_W        = 9;
   localparam int COUNT_W      = 9;

   localparam int WINDOW_MAX   = 256;
   localparam int NUM_CHANNELS = 4;
   localparam int WINDOW_RESET = 60;

   localparam int WIN_AW       = $clog2(WINDOW_MAX);
   localparam int CNT_W        = $clog2(WINDOW_MAX + 1);
   localparam int CH_AW        = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
   localparam int STORE_DEPTH  = NUM_CHANNELS * WINDOW_MAX;
   localparam int ADDR_W       = $clog2(STORE_DEPTH);
   localparam int SUM_W        = VALUE_W + WIN_AW;

   typedef struct packed {
      logic               valid;
      logic [CNT_W-1:0]   rem;
      logic [VALUE_W-1:0] nq;
      logic [CNT_W-1:0]   den;
   } div_stage_type;

endpackage

`default_nettype wire

### rtl/wmm_if.sv
// Channel interfaces of the tracker: sample requests, result responses and
// the window length register write. Depends on wmm_pkg.
`timescale 1ns / 1ps
`default_nettype none

interface wmm_req_if import wmm_pkg::*; ();
   logic                valid;
   logic                ready;
   logic [CHAN_W-1:0]   channel;
   logic [VALUE_W-1:0]  sample;

   modport source (output valid, channel, sample, input ready);
   modport sink   (input valid, channel, sample, output ready);
endinterface

interface wmm_rsp_if import wmm_pkg::*; ();
   logic                valid;
   logic                ready;
   logic [VALUE_W-1:0]  min_value;
   logic [VALUE_W-1:0]  max_value;
   logic [VALUE_W-1:0]  mean_value;
   logic [COUNT_W-1:0]  sample_count;

   modport source (output valid, min_value, max_value, mean_value, sample_count, input ready);
   modport sink   (input valid, min_value, max_value, mean_value, sample_count, output ready);
endinterface

interface wmm_csr_if import wmm_pkg::*; ();
   logic              valid;
   logic              ready;
   logic [CFG_W-1:0]  window_length;

   modport source (output valid, window_length, input ready);
   modport sink   (input valid, window_length, output ready);
endinterface

`default_nettype wire

### rtl/wmm_ram.sv
// Generic single-port RAM with registered read, used for the sample store.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

module wmm_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] addr,
   input  logic [WIDTH-1:0]         wdata,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (we) begin
         mem[addr] <= wdata;
      end
      rdata <= mem[addr];
   end

endmodule

`default_nettype wire

### rtl/wmm_div_cell.sv
// One restoring-division cell: settles one quotient bit and hands the partial
// remainder and shifted numerator/quotient word to its neighbor. Depends on wmm_pkg.
`timescale 1ns / 1ps
`default_nettype none

module wmm_div_cell import wmm_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  div_stage_type stage_in,
   output div_stage_type stage_out
);

   logic [CNT_W:0]   trial;
   logic             take;
   div_stage_type    stage_in_c;
   div_stage_type    stage_ff;

   assign trial = {stage_in.rem, stage_in.nq[VALUE_W-1]};
   assign take  = trial >= {1'b0, stage_in.den};

   always_comb begin
      stage_in_c.valid = stage_in.valid;
      stage_in_c.den   = stage_in.den;
      stage_in_c.rem   = take ? CNT_W'(trial - {1'b0, stage_in.den}) : CNT_W'(trial);
      stage_in_c.nq    = {stage_in.nq[VALUE_W-2:0], take};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         stage_ff.valid <= 1'b0;
      end else begin
         stage_ff.valid <= stage_in_c.valid;
      end
      stage_ff.rem <= stage_in_c.rem;
      stage_ff.nq  <= stage_in_c.nq;
      stage_ff.den <= stage_in_c.den;
   end

   assign stage_out = stage_ff;

endmodule

`default_nettype wire

### rtl/wmm_ctrl.sv
// Sequencer of the tracker: per-channel ring bookkeeping, sample store write,
// window rescan for min/max/sum, divider launch and the response register.
// Depends on wmm_pkg and the channel interfaces.
`timescale 1ns / 1ps
`default_nettype none

module wmm_ctrl import wmm_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   wmm_req_if.sink            req_if,
   wmm_rsp_if.source          rsp_if,
   wmm_csr_if.sink            csr_if,
   output logic               ram_we,
   output logic [ADDR_W-1:0]  ram_addr,
   output logic [VALUE_W-1:0] ram_wdata,
   input  logic [VALUE_W-1:0] ram_rdata,
   output div_stage_type      div_in,
   input  div_stage_type      div_out
);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_WRITE,
      ST_SCAN,
      ST_LAUNCH,
      ST_DIV
   } state_type;

   function automatic logic [CNT_W-1:0] clamp_len(input logic [CFG_W-1:0] v);
      logic [CNT_W-1:0] len;
      if (v == '0) begin
         len = CNT_W'(1);
      end else if (32'(v) > WINDOW_MAX) begin
         len = CNT_W'(WINDOW_MAX);
      end else begin
         len = CNT_W'(v);
      end
      return len;
   endfunction

   state_type          state_ff;
   logic [CNT_W-1:0]   len_ff;
   logic [CNT_W-1:0]   fill_ff   [NUM_CHANNELS];
   logic [WIN_AW-1:0]  oldest_ff [NUM_CHANNELS];
   logic [CH_AW-1:0]   ch_ff;
   logic [VALUE_W-1:0] sample_ff;
   logic [WIN_AW-1:0]  wpos_ff;
   logic [CNT_W-1:0]   cnt_ff;
   logic [CNT_W-1:0]   idx_ff;
   logic               rd_vld_ff;
   logic               first_ff;
   logic [VALUE_W-1:0] lo_ff;
   logic [VALUE_W-1:0] hi_ff;
   logic [SUM_W-1:0]   sum_ff;
   logic               rsp_valid_ff;
   logic [VALUE_W-1:0] rsp_min_ff;
   logic [VALUE_W-1:0] rsp_max_ff;
   logic [VALUE_W-1:0] rsp_mean_ff;
   logic [COUNT_W-1:0] rsp_count_ff;

   logic [CH_AW-1:0]   req_ch;
   logic               req_ok;
   logic [CNT_W-1:0]   cur_fill;
   logic [WIN_AW-1:0]  cur_oldest;
   logic               full;
   logic [WIN_AW-1:0]  wpos_in;
   logic [WIN_AW-1:0]  oldest_in;
   logic [CNT_W-1:0]   fill_in;
   logic               issue;
   logic [WIN_AW-1:0]  slot;

   assign req_ch     = CH_AW'(req_if.channel);
   assign req_ok     = 32'(req_if.channel) < NUM_CHANNELS;
   assign cur_fill   = fill_ff[req_ch];
   assign cur_oldest = oldest_ff[req_ch];
   assign full       = cur_fill >= len_ff;
   assign wpos_in    = full ? cur_oldest : cur_fill[WIN_AW-1:0];
   assign fill_in    = full ? len_ff : CNT_W'(cur_fill + CNT_W'(1));

   always_comb begin
      oldest_in = cur_oldest;
      if (full) begin
         if (CNT_W'(CNT_W'(cur_oldest) + CNT_W'(1)) == len_ff) begin
            oldest_in = '0;
         end else begin
            oldest_in = WIN_AW'(cur_oldest + WIN_AW'(1));
         end
      end
   end

   assign issue     = (state_ff == ST_SCAN) && (idx_ff != cnt_ff);
   assign slot      = (state_ff == ST_WRITE) ? wpos_ff : idx_ff[WIN_AW-1:0];
   assign ram_addr  = ADDR_W'(ADDR_W'(ch_ff) * ADDR_W'(WINDOW_MAX)) + ADDR_W'(slot);
   assign ram_we    = (state_ff == ST_WRITE);
   assign ram_wdata = sample_ff;

   always_comb begin
      div_in.valid = (state_ff == ST_LAUNCH) && !rsp_valid_ff;
      div_in.rem   = CNT_W'(sum_ff[SUM_W-1:VALUE_W]);
      div_in.nq    = sum_ff[VALUE_W-1:0];
      div_in.den   = cnt_ff;
   end

   assign req_if.ready        = (state_ff == ST_IDLE);
   assign csr_if.ready        = 1'b1;
   assign rsp_if.valid        = rsp_valid_ff;
   assign rsp_if.min_value    = rsp_min_ff;
   assign rsp_if.max_value    = rsp_max_ff;
   assign rsp_if.mean_value   = rsp_mean_ff;
   assign rsp_if.sample_count = rsp_count_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         len_ff       <= clamp_len(CFG_W'(WINDOW_RESET));
         fill_ff      <= '{default: '0};
         oldest_ff    <= '{default: '0};
         rd_vld_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         rd_vld_ff <= issue;
         if (rsp_valid_ff && rsp_if.ready) begin
            rsp_valid_ff <= 1'b0;
         end

         unique case (state_ff)
            ST_IDLE: begin
               if (req_if.valid && req_ok) begin
                  ch_ff             <= req_ch;
                  sample_ff         <= req_if.sample;
                  wpos_ff           <= wpos_in;
                  cnt_ff            <= fill_in;
                  fill_ff[req_ch]   <= fill_in;
                  oldest_ff[req_ch] <= oldest_in;
                  state_ff          <= ST_WRITE;
               end
            end
            ST_WRITE: begin
               idx_ff   <= '0;
               first_ff <= 1'b1;
               state_ff <= ST_SCAN;
            end
            ST_SCAN: begin
               if (issue) begin
                  idx_ff <= CNT_W'(idx_ff + CNT_W'(1));
               end
               if (rd_vld_ff) begin
                  first_ff <= 1'b0;
                  if (first_ff) begin
                     lo_ff  <= ram_rdata;
                     hi_ff  <= ram_rdata;
                     sum_ff <= SUM_W'(ram_rdata);
                  end else begin
                     if (ram_rdata < lo_ff) begin
                        lo_ff <= ram_rdata;
                     end
                     if (ram_rdata > hi_ff) begin
                        hi_ff <= ram_rdata;
                     end
                     sum_ff <= SUM_W'(sum_ff + SUM_W'(ram_rdata));
                  end
               end
               if (!issue && !rd_vld_ff) begin
                  state_ff <= ST_LAUNCH;
               end
            end
            ST_LAUNCH: begin
               if (!rsp_valid_ff) begin
                  state_ff <= ST_DIV;
               end
            end
            ST_DIV: begin
               if (div_out.valid) begin
                  rsp_min_ff   <= lo_ff;
                  rsp_max_ff   <= hi_ff;
                  rsp_mean_ff  <= div_out.nq;
                  rsp_count_ff <= COUNT_W'(cnt_ff);
                  rsp_valid_ff <= 1'b1;
                  state_ff     <= ST_IDLE;
               end
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase

         if (csr_if.valid) begin
            len_ff    <= clamp_len(csr_if.window_length);
            fill_ff   <= '{default: '0};
            oldest_ff <= '{default: '0};
         end
      end
   end

endmodule

`default_nettype wire

### rtl/window_min_max_mean_tracker_unit.sv
// Top level of the four-channel sliding-window min/max/mean tracker.
// Depends on wmm_pkg, the channel interfaces, wmm_ram, wmm_div_cell and wmm_ctrl.
`timescale 1ns / 1ps
`default_nettype none

// Each request transfer appends one Q16.16 sample to the named channel's window
// (dropping the oldest when full) and yields one response with the minimum,
// maximum, truncated mean and sample count of that window. Requests are taken
// one at a time. The rescan reads one stored sample per cycle through the
// single store port, and the mean comes from a row of 32 division cells, one
// quotient bit per cell. A finished response waits in an output register while
// the next request is written and scanned; that request's division starts only
// once the response has been taken. Writing window_length clears every channel;
// the sample store needs no clearing.
module window_min_max_mean_tracker_unit import wmm_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   wmm_req_if.sink    req_if,
   wmm_rsp_if.source  rsp_if,
   wmm_csr_if.sink    csr_if
);

   logic               ram_we;
   logic [ADDR_W-1:0]  ram_addr;
   logic [VALUE_W-1:0] ram_wdata;
   logic [VALUE_W-1:0] ram_rdata;
   div_stage_type      stage [VALUE_W+1];

   wmm_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_if    (req_if),
      .rsp_if    (rsp_if),
      .csr_if    (csr_if),
      .ram_we    (ram_we),
      .ram_addr  (ram_addr),
      .ram_wdata (ram_wdata),
      .ram_rdata (ram_rdata),
      .div_in    (stage[0]),
      .div_out   (stage[VALUE_W])
   );

   wmm_ram #(
      .WIDTH (VALUE_W),
      .DEPTH (STORE_DEPTH)
   ) u_store (
      .clock (clock),
      .we    (ram_we),
      .addr  (ram_addr),
      .wdata (ram_wdata),
      .rdata (ram_rdata)
   );

   for (genvar g = 0; g < VALUE_W; g++) begin : g_div
      wmm_div_cell u_cell (
         .clock     (clock),
         .reset     (reset),
         .stage_in  (stage[g]),
         .stage_out (stage[g+1])
      );
   end

endmodule

`default_nettype wire

### rtl/wmm_checker.sv
// Port-level checks for the tracker and the bind that attaches them to
// window_min_max_mean_tracker_unit. Depends on wmm_pkg.
`timescale 1ns / 1ps
`default_nettype none

module wmm_checker import wmm_pkg::*; (
   input logic               clock,
   input logic               reset,
   input logic               req_valid,
   input logic               req_ready,
   input logic [CHAN_W-1:0]  req_channel,
   input logic               rsp_valid,
   input logic               rsp_ready,
   input logic [VALUE_W-1:0] min_value,
   input logic [VALUE_W-1:0] max_value,
   input logic [VALUE_W-1:0] mean_value,
   input logic [COUNT_W-1:0] sample_count
);

   logic [1:0] pend_ff;
   logic       req_xfer;
   logic       rsp_xfer;

   assign req_xfer = req_valid && req_ready && (32'(req_channel) < NUM_CHANNELS);
   assign rsp_xfer = rsp_valid && rsp_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         pend_ff <= '0;
      end else if (req_xfer && !rsp_xfer) begin
         pend_ff <= 2'(pend_ff + 2'd1);
      end else if (rsp_xfer && !req_xfer) begin
         pend_ff <= 2'(pend_ff - 2'd1);
      end
   end

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(min_value) && $stable(max_value)
         && $stable(mean_value) && $stable(sample_count))
      else $error("response changed while stalled");

   a_rsp_has_req: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> pend_ff != 2'd0)
      else $error("response without an outstanding request");

   a_one_at_a_time: assert property (@(posedge clock) disable iff (reset)
      req_xfer |=> !req_ready)
      else $error("request taken while another is in progress");

   a_mean_bounds: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> min_value <= mean_value && mean_value <= max_value)
      else $error("mean outside min/max");

   a_count_nonzero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> sample_count != '0)
      else $error("empty window reported");

endmodule

bind window_min_max_mean_tracker_unit wmm_checker u_wmm_checker (
   .clock        (clock),
   .reset        (reset),
   .req_valid    (req_if.valid),
   .req_ready    (req_if.ready),
   .req_channel  (req_if.channel),
   .rsp_valid    (rsp_if.valid),
   .rsp_ready    (rsp_if.ready),
   .min_value    (rsp_if.min_value),
   .max_value    (rsp_if.max_value),
   .mean_value   (rsp_if.mean_value),
   .sample_count (rsp_if.sample_count)
);

`default_nettype wire
